// ----- hdl/tfd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermal fan drive law package
// Shared widths, constants, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package tfd_pkg;

  localparam int CountW = 16;
  localparam int RatioW = 8;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 16;
  localparam int AccW = 18;
  localparam int TgtW = 10;
  localparam int NumW = CountW + RatioW;

  localparam logic [CfgIdxW-1:0] RegHot = 2'd0;
  localparam logic [CfgIdxW-1:0] RegCold = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMinRatio = 2'd2;

  localparam logic [CountW-1:0] HotReset = 16'd16;
  localparam logic [CountW-1:0] ColdReset = 16'd104;
  localparam logic [RatioW-1:0] MinRatioReset = 8'd64;

  localparam logic signed [AccW-1:0] AcceptedReset = -18'sd80;
  localparam logic signed [AccW-1:0] MinCountChange = 18'sd2;
  localparam logic signed [TgtW-1:0] SlewMax = 10'sd20;
  localparam logic [RatioW-1:0] DriveFull = 8'd255;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_SLEW,
    S_APPLY
  } tfd_state_t;

endpackage

// ----- hdl/tfd_sample_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample channel
// Carries one thermistor count per beat.
// ----------------------------------------------------------------------------
interface tfd_sample_if;
  import tfd_pkg::*;

  logic              valid;
  logic              ready;
  logic [CountW-1:0] temp_count;

  modport source (output valid, output temp_count, input ready);
  modport sink (input valid, input temp_count, output ready);

endinterface

// ----- hdl/tfd_result_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Carries the drive ratio and its change flag, one beat per sample.
// ----------------------------------------------------------------------------
interface tfd_result_if;
  import tfd_pkg::*;

  logic              valid;
  logic              ready;
  logic [RatioW-1:0] drive_ratio;
  logic              drive_changed;

  modport source (output valid, output drive_ratio, output drive_changed, input ready);
  modport sink (input valid, input drive_ratio, input drive_changed, output ready);

endinterface

// ----- hdl/tfd_cfg_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries a register index and write data, one register per beat.
// ----------------------------------------------------------------------------
interface tfd_cfg_if;
  import tfd_pkg::*;

  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);

endinterface

// ----- hdl/thermal_fan_drive_law.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Thermal fan drive law
// Linear fan curve between two count thresholds with a slew limit, using a
// restoring divider stepped by a small sequencer.
//
//   channel   dir   beat contents
//   sample    in    temp_count
//   result    out   drive_ratio, drive_changed
//   cfg       in    index, data (0 hot, 1 cold, 2 min ratio)
//
// A ramp-region sample goes from accept to result through one evaluate
// state with the product, 24 divider steps of one quotient bit each, one
// slew state and one apply state. Other samples go from evaluate to apply,
// and the next accept comes in the idle state entered after the result load.
// Reset is synchronous and restores the register and state reset values.
// A waiting result does not block the next accept; only the apply step waits.
// ----------------------------------------------------------------------------
module thermal_fan_drive_law (
  input  logic         clk,
  input  logic         rst,
  tfd_sample_if.sink   sample,
  tfd_result_if.source result,
  tfd_cfg_if.sink      cfg
);
  import tfd_pkg::*;

  localparam int DivSteps = NumW;
  localparam int DivCntW = $clog2(DivSteps);

  tfd_state_t state, state_next;

  logic [CountW-1:0]      hot_thr;
  logic [CountW-1:0]      cold_thr;
  logic [RatioW-1:0]      min_ratio;

  logic signed [AccW-1:0] acc_count;
  logic [RatioW-1:0]      cmd_ratio;
  logic [RatioW-1:0]      wr_ratio;
  logic                   wr_valid;

  logic [CountW-1:0]      cnt;
  logic                   hold;
  logic                   upd_acc;
  logic signed [TgtW-1:0] tgt;
  logic [NumW-1:0]        quo;
  logic [CountW-1:0]      rem;
  logic [CountW-1:0]      den;
  logic [DivCntW-1:0]     div_cnt;

  logic                   res_valid;
  logic [RatioW-1:0]      res_ratio;
  logic                   res_changed;

  logic                   in_ready;
  logic                   out_load;

  logic signed [AccW-1:0] diff;
  logic                   small_step;
  logic                   is_cold;
  logic                   is_hot;
  logic [CountW:0]        trial;
  logic                   trial_ge;
  logic [RatioW-1:0]      slew_base;
  logic signed [TgtW-1:0] ramp_tgt;
  logic signed [TgtW-1:0] delta;
  logic [RatioW-1:0]      clamped;
  logic                   changed;

  assign diff       = signed'({2'b00, cnt}) - acc_count;
  assign small_step = (diff < MinCountChange) && (diff > -MinCountChange);
  assign is_cold    = cnt >= cold_thr;
  assign is_hot     = cnt < hot_thr;

  assign trial    = {rem, quo[NumW-1]};
  assign trial_ge = trial >= {1'b0, den};

  assign slew_base = (cmd_ratio == '0) ? min_ratio : cmd_ratio;
  assign ramp_tgt  = signed'({2'b00, DriveFull}) - signed'({2'b00, quo[RatioW-1:0]});
  assign delta     = ramp_tgt - signed'({2'b00, slew_base});

  always_comb begin
    if (tgt > signed'({2'b00, DriveFull})) begin
      clamped = DriveFull;
    end else if (tgt < 0) begin
      clamped = '0;
    end else if (tgt > 0 && tgt < signed'({2'b00, min_ratio})) begin
      clamped = min_ratio;
    end else begin
      clamped = tgt[RatioW-1:0];
    end
  end

  assign changed = !hold && (!wr_valid || wr_ratio != clamped);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (sample.valid) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (small_step || is_cold || is_hot) begin
          state_next = S_APPLY;
        end else begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_cnt == DivCntW'(DivSteps - 1)) begin
          state_next = S_SLEW;
        end
      end
      S_SLEW: state_next = S_APPLY;
      S_APPLY: begin
        if (!res_valid || result.ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    case (state)
      S_IDLE:  in_ready = 1'b1;
      S_APPLY: out_load = !res_valid || result.ready;
      default: begin
        in_ready = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hot_thr   <= HotReset;
      cold_thr  <= ColdReset;
      min_ratio <= MinRatioReset;
    end else if (cfg.valid) begin
      case (cfg.index)
        RegHot:      hot_thr <= cfg.data;
        RegCold:     cold_thr <= cfg.data;
        RegMinRatio: min_ratio <= cfg.data[RatioW-1:0];
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_count <= AcceptedReset;
      cmd_ratio <= '0;
      wr_ratio  <= '0;
      wr_valid  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (out_load) begin
        res_valid   <= 1'b1;
        res_ratio   <= changed ? clamped : wr_ratio;
        res_changed <= changed;
        if (!hold) begin
          cmd_ratio <= tgt[RatioW-1:0];
          if (upd_acc) begin
            acc_count <= signed'({2'b00, cnt});
          end
          if (changed) begin
            wr_ratio <= clamped;
            wr_valid <= 1'b1;
          end
        end
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cnt <= sample.temp_count;
      end
      S_EVAL: begin
        hold    <= small_step;
        upd_acc <= 1'b1;
        tgt     <= is_cold ? '0 : signed'({2'b00, DriveFull});
        quo     <= NumW'(DriveFull - min_ratio) * NumW'(cnt - hot_thr);
        den     <= cold_thr - hot_thr;
        rem     <= '0;
        div_cnt <= '0;
      end
      S_DIV: begin
        rem     <= trial_ge ? CountW'(trial - {1'b0, den}) : trial[CountW-1:0];
        quo     <= {quo[NumW-2:0], trial_ge};
        div_cnt <= div_cnt + 1'b1;
      end
      S_SLEW: begin
        if (delta > SlewMax) begin
          tgt     <= signed'({2'b00, slew_base}) + SlewMax;
          upd_acc <= 1'b0;
        end else if (delta < -SlewMax) begin
          tgt     <= signed'({2'b00, slew_base}) - SlewMax;
          upd_acc <= 1'b0;
        end else begin
          tgt <= ramp_tgt;
        end
      end
      default: ;
    endcase
  end

  assign sample.ready         = in_ready;
  assign cfg.ready            = 1'b1;
  assign result.valid         = res_valid;
  assign result.drive_ratio   = res_ratio;
  assign result.drive_changed = res_changed;

`ifndef NO_ASSERTIONS
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> !sample.ready)
    else $error("sample accepted while another is in progress");

  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < den))
    else $error("divider remainder not below divisor");

  a_quotient_fits: assert property (@(posedge clk) disable iff (rst)
    (state == S_SLEW) |-> (quo[NumW-1:RatioW] == '0))
    else $error("ramp quotient exceeds drive range");

  a_result_tracks_write: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.drive_ratio == wr_ratio))
    else $error("reported drive differs from written drive");

  a_changed_implies_written: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.drive_changed) |-> wr_valid)
    else $error("change reported without a written drive");
`endif

endmodule
